>>> design/three_axis_waypoint_interpolator_top_defines.svh
// Assertion macros for the waypoint interpolator top.
`ifndef THREE_AXIS_WAYPOINT_INTERPOLATOR_TOP_DEFINES_SVH
`define THREE_AXIS_WAYPOINT_INTERPOLATOR_TOP_DEFINES_SVH

// Checked at every rising edge, held off while reset is low.
`define TWI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TWI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> design/twi_pkg.sv
package twi_pkg;

    localparam int PosW       = 32;
    localparam int DurW       = 16;
    localparam int MulW       = DurW + 1;
    localparam int ProdW      = PosW + MulW;
    localparam int CntW       = 6;
    localparam int EntryW     = 3 * PosW + DurW;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic                   start;
        logic signed [PosW-1:0] delta;
        logic [MulW-1:0]        mult;
        logic [DurW-1:0]        divisor;
    } t_md_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             neg;
        logic [ProdW-1:0] quot;
    } t_md_rsp;

    // Quarter of a sine period per 16 entries, full scale 32.
    function automatic logic [5:0] sine_level(input logic [4:0] idx);
        logic [5:0] v;
        case (idx)
            5'd0:    v = 6'd0;
            5'd1:    v = 6'd3;
            5'd2:    v = 6'd6;
            5'd3:    v = 6'd9;
            5'd4:    v = 6'd12;
            5'd5:    v = 6'd15;
            5'd6:    v = 6'd18;
            5'd7:    v = 6'd20;
            5'd8:    v = 6'd23;
            5'd9:    v = 6'd25;
            5'd10:   v = 6'd27;
            5'd11:   v = 6'd28;
            5'd12:   v = 6'd30;
            5'd13:   v = 6'd31;
            5'd14:   v = 6'd31;
            5'd15:   v = 6'd32;
            5'd16:   v = 6'd32;
            5'd17:   v = 6'd32;
            5'd18:   v = 6'd31;
            5'd19:   v = 6'd31;
            5'd20:   v = 6'd30;
            5'd21:   v = 6'd28;
            5'd22:   v = 6'd27;
            5'd23:   v = 6'd25;
            5'd24:   v = 6'd23;
            5'd25:   v = 6'd20;
            5'd26:   v = 6'd18;
            5'd27:   v = 6'd15;
            5'd28:   v = 6'd12;
            5'd29:   v = 6'd9;
            5'd30:   v = 6'd6;
            5'd31:   v = 6'd3;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/three_axis_waypoint_interpolator_top.sv
// Push: one result, ready again once the result is registered, when the output is free.
// Tick on a moving segment: three results, one per axis, each through the serial
// multiply, the serial divide and control steps; the tick that ends a segment
// skips the multiply-divide and then loads the next waypoint, if one is queued.
// Idle tick: no result. One input item is worked on at a time.
// Reset (i_rst_n low at a clock edge) clears positions, deltas, segment and queue state.
`include "three_axis_waypoint_interpolator_top_defines.svh"

module three_axis_waypoint_interpolator_top #(
    parameter int QUEUE_DEPTH = twi_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic [15:0] i_duration,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_axis,
    output logic        o_phase_a_sign,
    output logic [5:0]  o_phase_a_level,
    output logic        o_phase_b_sign,
    output logic [5:0]  o_phase_b_level,
    output logic signed [31:0] o_position,
    output logic        o_segment_done,
    output logic [2:0]  o_queue_count,
    output logic        o_push_accepted,
    output logic        o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = twi_pkg::PosW;
    localparam int DW = twi_pkg::DurW;

    // The sequencer walks the three axes of a tick one after another; on a moving
    // segment each goes through the shared serial multiply-divide unit.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CALC    = 6'b000010,
        ST_WAITD   = 6'b000100,
        ST_FIN     = 6'b001000,
        ST_EMIT    = 6'b010000,
        ST_LOADEND = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [PW-1:0] r_pos   [0:2];
    logic [PW-1:0] n_pos   [0:2];
    logic [PW-1:0] r_delta [0:2];
    logic [PW-1:0] n_delta [0:2];
    logic [DW-1:0] r_seg, n_seg;
    logic [DW-1:0] r_tick, n_tick;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [1:0]    r_axis, n_axis;
    logic          r_is_push, n_is_push;
    logic          r_push_ok, n_push_ok;
    logic [PW-1:0] r_res_pos, n_res_pos;
    logic [PW-1:0] r_add_mag, n_add_mag;
    logic          r_add_neg, n_add_neg;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_axis, n_o_axis;
    logic          r_o_a_sign, n_o_a_sign;
    logic [5:0]    r_o_a_level, n_o_a_level;
    logic          r_o_b_sign, n_o_b_sign;
    logic [5:0]    r_o_b_level, n_o_b_level;
    logic [PW-1:0] r_o_pos, n_o_pos;
    logic          r_o_done, n_o_done;
    logic [2:0]    r_o_count, n_o_count;
    logic          r_o_push_ok, n_o_push_ok;
    logic          r_o_last, n_o_last;

    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_full;
    logic                        w_seg_end;
    logic                        w_load;
    logic [AW:0]                 w_tail_sum;
    logic [AW-1:0]               w_tail;
    logic [AW-1:0]               w_head_next;
    logic                        w_we;
    logic [twi_pkg::EntryW-1:0]  w_wdata;
    logic [twi_pkg::EntryW-1:0]  w_rdata;
    logic [PW-1:0]               w_tgt [0:2];
    logic [DW-1:0]               w_dur;
    logic [FW-1:0]               w_tick_count;
    logic [PW:0]                 w_qp;
    logic [PW:0]                 w_qm;
    logic [7:0]                  w_ib;
    twi_pkg::t_md_req            w_md_req;
    twi_pkg::t_md_rsp            w_md_rsp;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_fill == FW'(QUEUE_DEPTH));
    assign w_seg_end  = (r_tick == r_seg);

    // Ring buffer addressing: the tail is head plus fill, folded once.
    assign w_tail_sum  = (AW+1)'(r_head) + (AW+1)'(r_fill);
    assign w_tail      = (w_tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                         w_tail_sum[AW-1:0] - AW'(QUEUE_DEPTH) : w_tail_sum[AW-1:0];
    assign w_head_next = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign w_we    = w_in_acc && i_kind && !w_full;
    assign w_wdata = {i_duration, i_target_z, i_target_y, i_target_x};

    // The queue memory reads the entry that will be at the head after this
    // edge, every cycle. A load can then follow another load back to back,
    // and a push always passes through the emit state before a tick can take it,
    // so the registered read data is current when a waypoint is taken.
    twi_ram #(
        .Width(twi_pkg::EntryW),
        .Depth(QUEUE_DEPTH),
        .AddrW(AW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_tail),
        .i_wdata(w_wdata),
        .i_raddr(n_head),
        .o_rdata(w_rdata)
    );

    assign w_tgt[0] = w_rdata[PW-1:0];
    assign w_tgt[1] = w_rdata[2*PW-1:PW];
    assign w_tgt[2] = w_rdata[3*PW-1:2*PW];
    assign w_dur    = w_rdata[3*PW+DW-1:3*PW];

    twi_muldiv u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_md_req),
        .o_rsp  (w_md_rsp)
    );

    // The tick that ends a segment reports the fill after the next load.
    assign w_tick_count = (w_seg_end && (r_fill != '0)) ? r_fill - 1'b1 : r_fill;

    // Rounding step (1 + q) / 2 toward zero, worked on the quotient magnitude.
    // Only the low 32 bits of the result reach the wrapped position sum.
    assign w_qp = w_md_rsp.quot[PW:0] + 1'b1;
    assign w_qm = w_md_rsp.quot[PW:0] - 1'b1;

    assign w_ib = r_res_pos[7:0] + 8'd16;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_delta     = r_delta;
        n_seg       = r_seg;
        n_tick      = r_tick;
        n_head      = r_head;
        n_fill      = r_fill;
        n_axis      = r_axis;
        n_is_push   = r_is_push;
        n_push_ok   = r_push_ok;
        n_res_pos   = r_res_pos;
        n_add_mag   = r_add_mag;
        n_add_neg   = r_add_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_axis    = r_o_axis;
        n_o_a_sign  = r_o_a_sign;
        n_o_a_level = r_o_a_level;
        n_o_b_sign  = r_o_b_sign;
        n_o_b_level = r_o_b_level;
        n_o_pos     = r_o_pos;
        n_o_done    = r_o_done;
        n_o_count   = r_o_count;
        n_o_push_ok = r_o_push_ok;
        n_o_last    = r_o_last;
        w_load      = 1'b0;

        w_md_req.start   = 1'b0;
        w_md_req.delta   = r_delta[r_axis];
        w_md_req.mult    = {r_tick, 1'b1};
        w_md_req.divisor = r_seg;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_kind) begin
                        n_push_ok = !w_full;
                        if (!w_full) begin
                            n_fill = r_fill + 1'b1;
                        end
                        n_is_push = 1'b1;
                        n_state   = ST_EMIT;
                    end else if (r_seg == '0) begin
                        w_load = (r_fill != '0);
                    end else begin
                        n_is_push = 1'b0;
                        n_axis    = 2'd0;
                        n_state   = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                if (w_seg_end) begin
                    // Final tick: commit the target position of this axis.
                    n_pos[r_axis] = r_pos[r_axis] + r_delta[r_axis];
                    n_res_pos     = r_pos[r_axis] + r_delta[r_axis];
                    n_state       = ST_EMIT;
                end else begin
                    w_md_req.start = 1'b1;
                    n_state        = ST_WAITD;
                end
            end
            ST_WAITD: begin
                if (w_md_rsp.done) begin
                    n_add_neg = w_md_rsp.neg;
                    if (!w_md_rsp.neg) begin
                        n_add_mag = w_qp[PW:1];
                    end else if (w_md_rsp.quot == '0) begin
                        n_add_mag = '0;
                    end else begin
                        n_add_mag = w_qm[PW:1];
                    end
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_res_pos = r_add_neg ? r_pos[r_axis] - r_add_mag
                                      : r_pos[r_axis] + r_add_mag;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_is_push) begin
                        n_o_axis    = 2'd0;
                        n_o_a_sign  = 1'b0;
                        n_o_a_level = '0;
                        n_o_b_sign  = 1'b0;
                        n_o_b_level = '0;
                        n_o_pos     = '0;
                        n_o_done    = 1'b0;
                        n_o_count   = 3'(r_fill);
                        n_o_push_ok = r_push_ok;
                        n_o_last    = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_o_axis    = r_axis;
                        n_o_a_sign  = r_res_pos[5];
                        n_o_a_level = twi_pkg::sine_level(r_res_pos[4:0]);
                        n_o_b_sign  = w_ib[5];
                        n_o_b_level = twi_pkg::sine_level(w_ib[4:0]);
                        n_o_pos     = r_res_pos;
                        n_o_done    = (r_axis == 2'd2) && w_seg_end;
                        n_o_count   = 3'(w_tick_count);
                        n_o_push_ok = 1'b0;
                        n_o_last    = (r_axis == 2'd2);
                        if (r_axis != 2'd2) begin
                            n_axis  = r_axis + 1'b1;
                            n_state = ST_CALC;
                        end else if (w_seg_end) begin
                            n_seg   = '0;
                            n_state = (r_fill != '0) ? ST_LOADEND : ST_IDLE;
                        end else begin
                            n_tick  = r_tick + 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_LOADEND: begin
                w_load  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Take the head waypoint: deltas from the committed positions.
        if (w_load) begin
            for (int k = 0; k < 3; k++) begin
                n_delta[k] = w_tgt[k] - r_pos[k];
            end
            n_seg  = w_dur;
            n_tick = '0;
            n_head = w_head_next;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seg       <= '0;
            r_tick      <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_axis      <= '0;
            r_is_push   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k]   <= '0;
                r_delta[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_tick      <= n_tick;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_axis      <= n_axis;
            r_is_push   <= n_is_push;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_delta     <= n_delta;
        end
        r_push_ok   <= n_push_ok;
        r_res_pos   <= n_res_pos;
        r_add_mag   <= n_add_mag;
        r_add_neg   <= n_add_neg;
        r_o_axis    <= n_o_axis;
        r_o_a_sign  <= n_o_a_sign;
        r_o_a_level <= n_o_a_level;
        r_o_b_sign  <= n_o_b_sign;
        r_o_b_level <= n_o_b_level;
        r_o_pos     <= n_o_pos;
        r_o_done    <= n_o_done;
        r_o_count   <= n_o_count;
        r_o_push_ok <= n_o_push_ok;
        r_o_last    <= n_o_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_axis          = r_o_axis;
    assign o_phase_a_sign  = r_o_a_sign;
    assign o_phase_a_level = r_o_a_level;
    assign o_phase_b_sign  = r_o_b_sign;
    assign o_phase_b_level = r_o_b_level;
    assign o_position      = r_o_pos;
    assign o_segment_done  = r_o_done;
    assign o_queue_count   = r_o_count;
    assign o_push_accepted = r_o_push_ok;
    assign o_last          = r_o_last;

    `TWI_ASSERT(a_fill_bound, r_fill <= FW'(QUEUE_DEPTH), "queue fill beyond depth")
    `TWI_ASSERT(a_tick_bound, (r_seg != '0) |-> (r_tick <= r_seg), "tick past segment end")
    `TWI_ASSERT(a_md_done, w_md_rsp.done |-> (r_state == ST_WAITD), "divider done unexpected")
    `TWI_ASSERT(a_md_start, w_md_req.start |-> !w_md_rsp.busy, "divider started while busy")

endmodule

>>> design/twi_ram.sv
module twi_ram #(
    parameter int Width = 8,
    parameter int Depth = 4,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [0:Depth-1];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/twi_muldiv.sv
// Bit-serial signed multiply (one multiplier bit per cycle) followed by a
// restoring divide (one quotient bit per cycle), in sign-magnitude form.
module twi_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twi_pkg::t_md_req i_req,
    output twi_pkg::t_md_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DIV  = 3'b100
    } t_md_state;

    t_md_state r_state, n_state;
    logic [twi_pkg::CntW-1:0]  r_cnt, n_cnt;
    logic [twi_pkg::ProdW-1:0] r_p, n_p;
    logic [twi_pkg::PosW-1:0]  r_mag, n_mag;
    logic [twi_pkg::DurW-1:0]  r_rem, n_rem;
    logic [twi_pkg::DurW-1:0]  r_div, n_div;
    logic                      r_neg, n_neg;
    logic                      r_done, n_done;

    logic [twi_pkg::PosW:0]    w_sum;
    logic [twi_pkg::DurW:0]    w_sh;
    logic [twi_pkg::DurW:0]    w_diff;
    logic                      w_ge;

    always_comb begin
        w_sum  = {1'b0, r_p[twi_pkg::ProdW-1:twi_pkg::MulW]}
               + (r_p[0] ? {1'b0, r_mag} : '0);
        w_sh   = {r_rem, r_p[twi_pkg::ProdW-1]};
        w_diff = w_sh - {1'b0, r_div};
        w_ge   = (w_sh >= {1'b0, r_div});

        n_state = r_state;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_done  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_neg   = i_req.delta[twi_pkg::PosW-1];
                    n_mag   = i_req.delta[twi_pkg::PosW-1] ?
                              (twi_pkg::PosW'(0) - i_req.delta) : i_req.delta;
                    n_p     = {{twi_pkg::PosW{1'b0}}, i_req.mult};
                    n_div   = i_req.divisor;
                    n_rem   = '0;
                    n_cnt   = twi_pkg::CntW'(twi_pkg::MulW - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_p = {w_sum, r_p[twi_pkg::MulW-1:1]};
                if (r_cnt == '0) begin
                    n_cnt   = twi_pkg::CntW'(twi_pkg::ProdW - 1);
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[twi_pkg::DurW-1:0] : w_sh[twi_pkg::DurW-1:0];
                n_p   = {r_p[twi_pkg::ProdW-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_p   <= n_p;
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.quot = r_p;

endmodule
